### rtl/ray_quadric_intersect_assert.svh
// Assertion shorthands used by the checker file rqi_checker.sv.
`ifndef RAY_QUADRIC_INTERSECT_ASSERT_SVH
`define RAY_QUADRIC_INTERSECT_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define RQI_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("rqi: invariant violated");

// Check an implication; the consequent may open with a fixed delay.
`define RQI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("rqi: implication violated");

`endif

### rtl/rqi_pkg.sv
package rqi_pkg;

	localparam int LANE_W          = 32;
	localparam int COEF_W          = 32;
	localparam int CFG_W           = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_XX_YY = 3'd0,
		REG_ZZ_WW = 3'd1,
		REG_XY_XZ = 3'd2,
		REG_XW_YZ = 3'd3,
		REG_YW_ZW = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_MISS  = 2'd1,
		ST_DEGEN = 2'd2
	} status_t;

endpackage

### rtl/rqi_isqrt.sv
module rqi_isqrt import rqi_pkg::*; #(
	parameter int RW = COORD_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [2*RW-1:0] in_x,
	output logic            out_valid,
	output logic [RW-1:0]   out_root
);

	localparam int DW = 2 * RW;

	logic          vld_s  [RW];
	logic [DW-1:0] rem_s  [RW];
	logic [DW-1:0] root_s [RW];

	// One result bit per stage, digit-by-digit square root.
	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam logic [DW-1:0] BIT = DW'(1) << (DW - 2 - 2 * k);
		logic          v_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] root_in;
		logic [DW-1:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = in_x;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign trial = root_in + BIT;
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? rem_in - trial : rem_in;
			root_s[k] <= ge ? (root_in >> 1) + BIT : root_in >> 1;
		end
	end

	assign out_valid = vld_s[RW-1];
	assign out_root  = root_s[RW-1][RW-1:0];

endmodule

### rtl/rqi_div.sv
module rqi_div import rqi_pkg::*; #(
	parameter int NW  = COORD_WIDTH_DEF + 2 + FRAC_BITS_DEF,
	parameter int DVW = COORD_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [NW-1:0]  in_num,
	input  logic [DVW-1:0] in_den,
	output logic           out_valid,
	output logic [NW-1:0]  out_quo
);

	logic           vld_s [NW];
	logic [NW-1:0]  num_s [NW];
	logic [DVW-1:0] den_s [NW];
	logic [DVW-1:0] rem_s [NW];
	logic [NW-1:0]  quo_s [NW];

	// Restoring division, one quotient bit per stage, dividend shifted out MSB first.
	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic           v_in;
		logic [NW-1:0]  n_in;
		logic [DVW-1:0] d_in;
		logic [DVW-1:0] r_in;
		logic [NW-1:0]  q_in;
		logic [DVW:0]   trial;
		logic [DVW:0]   diff;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign n_in = in_num;
			assign d_in = in_den;
			assign r_in = '0;
			assign q_in = '0;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign n_in = num_s[k-1];
			assign d_in = den_s[k-1];
			assign r_in = rem_s[k-1];
			assign q_in = quo_s[k-1];
		end

		assign trial = {r_in, n_in[NW-1]};
		assign ge    = trial >= {1'b0, d_in};
		assign diff  = trial - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			num_s[k] <= n_in << 1;
			den_s[k] <= d_in;
			rem_s[k] <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
			quo_s[k] <= {q_in[NW-2:0], ge};
		end
	end

	assign out_valid = vld_s[NW-1];
	assign out_quo   = quo_s[NW-1];

endmodule

### rtl/ray_quadric_intersect.sv
// Ray against quadric x'Ax = 0, fully pipelined: one ray accepted every clock cycle.
// The square root adds COORD_WIDTH stages and each root divider
// COORD_WIDTH + FRAC_BITS + 2 stages.
// Result strobe done lasts one cycle; the receiver cannot stall; busy stays low.
// arst_n clears the valid bits and the coefficient registers to zero.
module ray_quadric_intersect import rqi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [LANE_W-1:0]    origin_x,
	input  logic signed [LANE_W-1:0]    origin_y,
	input  logic signed [LANE_W-1:0]    origin_z,
	input  logic signed [LANE_W-1:0]    dir_x,
	input  logic signed [LANE_W-1:0]    dir_y,
	input  logic signed [LANE_W-1:0]    dir_z,
	output logic                        done,
	output logic [1:0]                  status,
	output logic signed [LANE_W-1:0]    t_near,
	output logic signed [LANE_W-1:0]    t_far,
	output logic signed [LANE_W-1:0]    hit_x,
	output logic signed [LANE_W-1:0]    hit_y,
	output logic signed [LANE_W-1:0]    hit_z,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data
);

	localparam int CW   = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int P1W  = COEF_W + CW;
	localparam int S1W  = P1W - F;
	localparam int P3W  = 2 * CW;
	localparam int S3W  = P3W - F;
	localparam int DW   = 2 * CW;
	localparam int NNW  = CW + 2;
	localparam int NW   = NNW + F;
	localparam int WIDE = COEF_W + CW + 4;

	localparam logic signed [WIDE-1:0] LMAX = {{(WIDE-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [WIDE-1:0] LMIN = {{(WIDE-CW+1){1'b1}}, {(CW-1){1'b0}}};
	localparam logic [NW-1:0] QPOS = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic [NW-1:0] QNEG = NW'(1) << (CW - 1);

	typedef logic [2:0][CW-1:0] vec_t;

	typedef struct packed {
		status_t          st;
		logic [CW-1:0]    h;
		logic [CW-1:0]    a;
		vec_t             o;
		vec_t             d;
	} sq_pay_t;

	typedef struct packed {
		status_t st;
		logic    neg_n;
		logic    neg_f;
		vec_t    o;
		vec_t    d;
	} dv_pay_t;

	function automatic logic signed [CW-1:0] sat_lane(input logic signed [WIDE-1:0] x);
		logic signed [CW-1:0] r;
		if (x > LMAX) begin
			r = LMAX[CW-1:0];
		end else if (x < LMIN) begin
			r = LMIN[CW-1:0];
		end else begin
			r = x[CW-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [CW-1:0] sat_quo(input logic [NW-1:0] q, input logic neg);
		logic signed [CW-1:0] r;
		if (!neg) begin
			r = (q > QPOS) ? QPOS[CW-1:0] : q[CW-1:0];
		end else begin
			r = (q > QNEG) ? QNEG[CW-1:0] : -q[CW-1:0];
		end
		return r;
	endfunction

	// Configuration
	logic [CFG_W-1:0] xx_yy_q, zz_ww_q, xy_xz_q, xw_yz_q, yw_zw_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xx_yy_q <= '0;
			zz_ww_q <= '0;
			xy_xz_q <= '0;
			xw_yz_q <= '0;
			yw_zw_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_XX_YY: xx_yy_q <= cfg_data;
				REG_ZZ_WW: zz_ww_q <= cfg_data;
				REG_XY_XZ: xy_xz_q <= cfg_data;
				REG_XW_YZ: xw_yz_q <= cfg_data;
				REG_YW_ZW: yw_zw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [COEF_W-1:0] m [4][4];

	always_comb begin
		m[0][0] = xx_yy_q[31:0];
		m[1][1] = xx_yy_q[63:32];
		m[2][2] = zz_ww_q[31:0];
		m[3][3] = zz_ww_q[63:32];
		m[0][1] = xy_xz_q[31:0];
		m[1][0] = xy_xz_q[31:0];
		m[0][2] = xy_xz_q[63:32];
		m[2][0] = xy_xz_q[63:32];
		m[0][3] = xw_yz_q[31:0];
		m[3][0] = xw_yz_q[31:0];
		m[1][2] = xw_yz_q[63:32];
		m[2][1] = xw_yz_q[63:32];
		m[1][3] = yw_zw_q[31:0];
		m[3][1] = yw_zw_q[31:0];
		m[2][3] = yw_zw_q[63:32];
		m[3][2] = yw_zw_q[63:32];
	end

	// Stage 1: products of A with d and o
	vec_t o_in, d_in;

	assign o_in[0] = origin_x[CW-1:0];
	assign o_in[1] = origin_y[CW-1:0];
	assign o_in[2] = origin_z[CW-1:0];
	assign d_in[0] = dir_x[CW-1:0];
	assign d_in[1] = dir_y[CW-1:0];
	assign d_in[2] = dir_z[CW-1:0];

	logic                     valid_s1;
	logic signed [S1W-1:0]    pd_s1 [4][3];
	logic signed [S1W-1:0]    po_s1 [4][3];
	logic signed [COEF_W-1:0] mw_s1 [4];
	vec_t                     o_s1, d_s1;

	for (genvar i = 0; i < 4; i++) begin : g_row1
		for (genvar j = 0; j < 3; j++) begin : g_col1
			logic signed [P1W-1:0] prod_d, prod_o;
			assign prod_d = m[i][j] * signed'(d_in[j]);
			assign prod_o = m[i][j] * signed'(o_in[j]);
			always_ff @(posedge clk) begin
				pd_s1[i][j] <= prod_d[P1W-1:F];
				po_s1[i][j] <= prod_o[P1W-1:F];
			end
		end
		// the w component of o is exactly one, so its product is the coefficient
		always_ff @(posedge clk) begin
			mw_s1[i] <= m[i][3];
		end
	end

	always_ff @(posedge clk) begin
		o_s1 <= o_in;
		d_s1 <= d_in;
	end

	// Stage 2: A*d and A*o
	logic                 valid_s2;
	logic signed [CW-1:0] ad_s2 [4];
	logic signed [CW-1:0] ao_s2 [4];
	vec_t                 o_s2, d_s2;

	for (genvar i = 0; i < 4; i++) begin : g_row2
		logic signed [WIDE-1:0] sum_d, sum_o;
		assign sum_d = WIDE'(pd_s1[i][0]) + WIDE'(pd_s1[i][1]) + WIDE'(pd_s1[i][2]);
		assign sum_o = WIDE'(po_s1[i][0]) + WIDE'(po_s1[i][1]) + WIDE'(po_s1[i][2])
			+ WIDE'(mw_s1[i]);
		always_ff @(posedge clk) begin
			ad_s2[i] <= sat_lane(sum_d);
			ao_s2[i] <= sat_lane(sum_o);
		end
	end

	always_ff @(posedge clk) begin
		o_s2 <= o_s1;
		d_s2 <= d_s1;
	end

	// Stage 3: terms of a, h and c
	logic                 valid_s3;
	logic signed [S3W-1:0] qa_s3 [3];
	logic signed [S3W-1:0] qh_s3 [3];
	logic signed [S3W-1:0] qc_s3 [3];
	logic signed [CW-1:0]  adw_s3, aow_s3;
	vec_t                  o_s3, d_s3;

	for (genvar i = 0; i < 3; i++) begin : g_term3
		logic signed [P3W-1:0] pa, ph, pc;
		assign pa = signed'(d_s2[i]) * ad_s2[i];
		assign ph = signed'(o_s2[i]) * ad_s2[i];
		assign pc = signed'(o_s2[i]) * ao_s2[i];
		always_ff @(posedge clk) begin
			qa_s3[i] <= pa[P3W-1:F];
			qh_s3[i] <= ph[P3W-1:F];
			qc_s3[i] <= pc[P3W-1:F];
		end
	end

	always_ff @(posedge clk) begin
		adw_s3 <= ad_s2[3];
		aow_s3 <= ao_s2[3];
		o_s3   <= o_s2;
		d_s3   <= d_s2;
	end

	// Stage 4: a, h, c
	logic                 valid_s4;
	logic signed [CW-1:0] a_s4, h_s4, c_s4;
	vec_t                 o_s4, d_s4;
	logic signed [WIDE-1:0] sum_a, sum_h, sum_c;

	assign sum_a = WIDE'(qa_s3[0]) + WIDE'(qa_s3[1]) + WIDE'(qa_s3[2]);
	assign sum_h = WIDE'(qh_s3[0]) + WIDE'(qh_s3[1]) + WIDE'(qh_s3[2]) + WIDE'(adw_s3);
	assign sum_c = WIDE'(qc_s3[0]) + WIDE'(qc_s3[1]) + WIDE'(qc_s3[2]) + WIDE'(aow_s3);

	always_ff @(posedge clk) begin
		a_s4 <= sat_lane(sum_a);
		h_s4 <= sat_lane(sum_h);
		c_s4 <= sat_lane(sum_c);
		o_s4 <= o_s3;
		d_s4 <= d_s3;
	end

	// Stage 5: h*h and a*c
	logic                  valid_s5;
	logic signed [P3W-1:0] hh_s5, p_s5;
	logic signed [CW-1:0]  a_s5, h_s5;
	vec_t                  o_s5, d_s5;

	always_ff @(posedge clk) begin
		hh_s5 <= h_s4 * h_s4;
		p_s5  <= a_s4 * c_s4;
		a_s5  <= a_s4;
		h_s5  <= h_s4;
		o_s5  <= o_s4;
		d_s5  <= d_s4;
	end

	// Stage 6: discriminant and status
	logic                  valid_s6;
	logic [DW-1:0]         disc_s6;
	sq_pay_t               pay_s6;
	logic signed [P3W:0]   disc_full;
	status_t               st_nxt;

	assign disc_full = (P3W+1)'(hh_s5) - (P3W+1)'(p_s5);

	always_comb begin
		if (a_s5 == '0) begin
			st_nxt = ST_DEGEN;
		end else if ((p_s5 > 0) && (p_s5 > hh_s5)) begin
			st_nxt = ST_MISS;
		end else begin
			st_nxt = ST_HIT;
		end
	end

	always_ff @(posedge clk) begin
		disc_s6 <= disc_full[DW-1:0];
		pay_s6  <= '{st: st_nxt, h: h_s5, a: a_s5, o: o_s5, d: d_s5};
	end

	// Square root with its side payload
	logic          sq_valid;
	logic [CW-1:0] sq_root;
	sq_pay_t       sq_dly [CW];

	rqi_isqrt #(.RW(CW)) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s6),
		.in_x      (disc_s6),
		.out_valid (sq_valid),
		.out_root  (sq_root)
	);

	always_ff @(posedge clk) begin
		sq_dly[0] <= pay_s6;
		for (int k = 1; k < CW; k++) begin
			sq_dly[k] <= sq_dly[k-1];
		end
	end

	// Stage 7: root numerators, magnitudes and signs
	logic                  valid_s7;
	logic [NNW-1:0]        un_n_s7, un_f_s7;
	logic [CW-1:0]         ua_s7;
	dv_pay_t               pay_s7;
	sq_pay_t               sq_out;
	logic signed [NNW-1:0] nn, nf;
	logic signed [CW:0]    a_ext;

	assign sq_out = sq_dly[CW-1];
	assign nn     = -NNW'(signed'(sq_out.h)) - signed'(NNW'(sq_root));
	assign nf     = -NNW'(signed'(sq_out.h)) + signed'(NNW'(sq_root));
	assign a_ext  = (CW+1)'(signed'(sq_out.a));

	always_ff @(posedge clk) begin
		un_n_s7 <= nn[NNW-1] ? -nn : nn;
		un_f_s7 <= nf[NNW-1] ? -nf : nf;
		ua_s7   <= a_ext[CW] ? CW'(-a_ext) : CW'(a_ext);
		pay_s7  <= '{st: sq_out.st,
			neg_n: nn[NNW-1] ^ sq_out.a[CW-1],
			neg_f: nf[NNW-1] ^ sq_out.a[CW-1],
			o: sq_out.o, d: sq_out.d};
	end

	// Two dividers for the roots
	logic          dn_valid, df_valid;
	logic [NW-1:0] qn, qf;
	dv_pay_t       dv_dly [NW];

	rqi_div #(.NW(NW), .DVW(CW)) u_div_near (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s7),
		.in_num    ({un_n_s7, {F{1'b0}}}),
		.in_den    (ua_s7),
		.out_valid (dn_valid),
		.out_quo   (qn)
	);

	rqi_div #(.NW(NW), .DVW(CW)) u_div_far (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s7),
		.in_num    ({un_f_s7, {F{1'b0}}}),
		.in_den    (ua_s7),
		.out_valid (df_valid),
		.out_quo   (qf)
	);

	always_ff @(posedge clk) begin
		dv_dly[0] <= pay_s7;
		for (int k = 1; k < NW; k++) begin
			dv_dly[k] <= dv_dly[k-1];
		end
	end

	// Stage 8: signed, saturated roots
	logic                 valid_s8;
	logic signed [CW-1:0] tn_s8, tf_s8;
	status_t              st_s8;
	vec_t                 o_s8, d_s8;
	dv_pay_t              dv_out;

	assign dv_out = dv_dly[NW-1];

	always_ff @(posedge clk) begin
		tn_s8 <= sat_quo(qn, dv_out.neg_n);
		tf_s8 <= sat_quo(qf, dv_out.neg_f);
		st_s8 <= dv_out.st;
		o_s8  <= dv_out.o;
		d_s8  <= dv_out.d;
	end

	// Stage 9: d * t_near
	logic                  valid_s9;
	logic signed [S3W-1:0] hp_s9 [3];
	logic signed [CW-1:0]  tn_s9, tf_s9;
	status_t               st_s9;
	vec_t                  o_s9;

	for (genvar i = 0; i < 3; i++) begin : g_hit9
		logic signed [P3W-1:0] ph;
		assign ph = signed'(d_s8[i]) * tn_s8;
		always_ff @(posedge clk) begin
			hp_s9[i] <= ph[P3W-1:F];
		end
	end

	always_ff @(posedge clk) begin
		tn_s9 <= tn_s8;
		tf_s9 <= tf_s8;
		st_s9 <= st_s8;
		o_s9  <= o_s8;
	end

	// Stage 10: hit point and result register; zero everything but status on no hit
	logic                 valid_s10;
	status_t              st_s10;
	logic signed [CW-1:0] tn_s10, tf_s10;
	logic signed [CW-1:0] hit_s10 [3];
	logic                 is_hit;

	assign is_hit = st_s9 == ST_HIT;

	for (genvar i = 0; i < 3; i++) begin : g_hit10
		logic signed [WIDE-1:0] sum_p;
		assign sum_p = WIDE'(signed'(o_s9[i])) + WIDE'(hp_s9[i]);
		always_ff @(posedge clk) begin
			hit_s10[i] <= is_hit ? sat_lane(sum_p) : '0;
		end
	end

	always_ff @(posedge clk) begin
		st_s10 <= st_s9;
		tn_s10 <= is_hit ? tn_s9 : '0;
		tf_s10 <= is_hit ? tf_s9 : '0;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			valid_s1  <= start && !busy;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= sq_valid;
			valid_s8  <= dn_valid && df_valid;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	assign done   = valid_s10;
	assign status = st_s10;
	assign t_near = LANE_W'(tn_s10);
	assign t_far  = LANE_W'(tf_s10);
	assign hit_x  = LANE_W'(hit_s10[0]);
	assign hit_y  = LANE_W'(hit_s10[1]);
	assign hit_z  = LANE_W'(hit_s10[2]);

endmodule

### rtl/rqi_checker.sv
`include "ray_quadric_intersect_assert.svh"

module rqi_checker import rqi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic [1:0]               status,
	input logic signed [LANE_W-1:0] t_near,
	input logic signed [LANE_W-1:0] t_far,
	input logic signed [LANE_W-1:0] hit_x,
	input logic signed [LANE_W-1:0] hit_y,
	input logic signed [LANE_W-1:0] hit_z,
	input logic                     cfg_ready
);

	localparam int LAT = 2 * COORD_WIDTH + FRAC_BITS + 12;

	`RQI_ASSERT_ALWAYS(a_never_stalls, clk, arst_n, !busy && cfg_ready)
	`RQI_ASSERT_IMPLY(a_latency, clk, arst_n, start && !busy, ##LAT done)
	`RQI_ASSERT_IMPLY(a_no_spurious, clk, arst_n, done, $past(start && !busy, LAT))
	`RQI_ASSERT_IMPLY(a_zero_on_fail, clk, arst_n, done && status != ST_HIT, t_near == 0 && t_far == 0 && hit_x == 0 && hit_y == 0 && hit_z == 0)

endmodule

bind ray_quadric_intersect rqi_checker #(
	.COORD_WIDTH (COORD_WIDTH),
	.FRAC_BITS   (FRAC_BITS)
) u_rqi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.t_near    (t_near),
	.t_far     (t_far),
	.hit_x     (hit_x),
	.hit_y     (hit_y),
	.hit_z     (hit_z),
	.cfg_ready (cfg_ready)
);

### bench/tb_ray_quadric_intersect.sv
`timescale 1ns / 100ps

module tb_ray_quadric_intersect;
	import rqi_pkg::*;

	localparam int FRAC       = FRAC_BITS_DEF;
	localparam int NUM_REGS   = 5;
	localparam int PIPE_DEPTH = 2 * COORD_WIDTH_DEF + FRAC_BITS_DEF + 12;
	localparam int STALL_MAX  = 2000;
	localparam longint ONE    = 64'sd1 <<< FRAC;
	// matrix position -> coefficient number (xx yy zz ww xy xz xw yz yw zw)
	localparam int COEF_POS [4][4] = '{'{0, 4, 5, 6}, '{4, 1, 7, 8},
		'{5, 7, 2, 9}, '{6, 8, 9, 3}};

	typedef struct {
		status_t            st;
		logic signed [31:0] tn, tf, hx, hy, hz;
	} ray_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] t_near, t_far, hit_x, hit_y, hit_z;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	logic [63:0]  coef_regs [NUM_REGS];
	ray_result_t  pending_results [$];
	int           errors = 0, rays_sent = 0, cfg_writes = 0;
	int           n_hit = 0, n_miss = 0, n_degen = 0;
	int           idle_pct = 0;
	int           quiet_cycles = 0;

	ray_quadric_intersect u_top (.*);

	always #6 clk = ~clk;

	function automatic longint sat_lane(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint coef_of(int k);
		logic [63:0] r;
		int          hi;
		r  = coef_regs[k < 4 ? k / 2 : (k - 4) / 2 + 2];
		hi = k < 4 ? k & 1 : (k - 4) & 1;
		return hi ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] rem, root, b;
		rem = x;
		root = 0;
		b = 64'd1 << 62;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic longint root_quot(longint n, longint a);
		logic [63:0] un, ua, q;
		longint      r;
		un = n < 0 ? -n : n;
		ua = a < 0 ? -a : a;
		q  = (un << FRAC) / ua;
		r  = q;
		if ((n < 0) != (a < 0)) r = -r;
		return sat_lane(r);
	endfunction

	function automatic ray_result_t intersect_ray(logic signed [31:0] ox, oy, oz,
			logic signed [31:0] dx, dy, dz);
		ray_result_t res;
		longint      o[4], d[4], ad[4], ao[4];
		longint      m, sd, so, a, h, c, p, s, tn, tf;
		logic [63:0] hh, disc;
		o = '{ox, oy, oz, ONE};
		d = '{dx, dy, dz, 0};
		res = '{ST_HIT, 0, 0, 0, 0, 0};
		for (int i = 0; i < 4; i++) begin
			sd = 0;
			so = 0;
			for (int j = 0; j < 4; j++) begin
				m = coef_of(COEF_POS[i][j]);
				sd += (m * d[j]) >>> FRAC;
				so += (m * o[j]) >>> FRAC;
			end
			ad[i] = sat_lane(sd);
			ao[i] = sat_lane(so);
		end
		a = 0; h = 0; c = 0;
		for (int i = 0; i < 4; i++) begin
			a += (d[i] * ad[i]) >>> FRAC;
			h += (o[i] * ad[i]) >>> FRAC;
			c += (o[i] * ao[i]) >>> FRAC;
		end
		a = sat_lane(a);
		h = sat_lane(h);
		c = sat_lane(c);
		if (a == 0) begin
			res.st = ST_DEGEN;
			return res;
		end
		hh = h * h;
		p  = a * c;
		if (p <= 0) begin
			disc = hh + 64'(-p);
		end else if (64'(p) > hh) begin
			res.st = ST_MISS;
			return res;
		end else begin
			disc = hh - 64'(p);
		end
		s  = floor_sqrt(disc);
		tn = root_quot(-h - s, a);
		tf = root_quot(-h + s, a);
		res.tn = tn;
		res.tf = tf;
		res.hx = sat_lane(o[0] + ((d[0] * tn) >>> FRAC));
		res.hy = sat_lane(o[1] + ((d[1] * tn) >>> FRAC));
		res.hz = sat_lane(o[2] + ((d[2] * tn) >>> FRAC));
		return res;
	endfunction

	task automatic drain_pipeline();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		if (idx < NUM_REGS) coef_regs[idx] = val;
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_quadric(logic [63:0] xx_yy, zz_ww, xy_xz, xw_yz, yw_zw);
		drain_pipeline();
		write_coef(REG_XX_YY, xx_yy);
		write_coef(REG_ZZ_WW, zz_ww);
		write_coef(REG_XY_XZ, xy_xz);
		write_coef(REG_XW_YZ, xw_yz);
		write_coef(REG_YW_ZW, yw_zw);
	endtask

	// Called at a rising edge; returns at the edge that took the beat, or after an idle gap drawn by idle_pct.
	task automatic send_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
		start    <= 1'b1;
		origin_x <= ox; origin_y <= oy; origin_z <= oz;
		dir_x    <= dx; dir_y    <= dy; dir_z    <= dz;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		pending_results.push_back(intersect_ray(ox, oy, oz, dx, dy, dz));
		rays_sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		ray_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, status %0d", $time, status);
			end else begin
				exp_r = pending_results.pop_front();
				check_field("status", exp_r.st, status);
				check_field("t_near", exp_r.tn, t_near);
				check_field("t_far", exp_r.tf, t_far);
				check_field("hit_x", exp_r.hx, hit_x);
				check_field("hit_y", exp_r.hy, hit_y);
				check_field("hit_z", exp_r.hz, hit_z);
				case (exp_r.st)
					ST_HIT:  n_hit++;
					ST_MISS: n_miss++;
					default: n_degen++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("%0t: timeout, %0d results outstanding", $time,
				pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(9) == 0) return $urandom;
		return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
	endfunction

	function automatic logic [63:0] rand_coef_pair(bit wide);
		logic [31:0] lo, hi;
		if (wide) return {$urandom, $urandom};
		lo = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
		hi = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
		return {hi, lo};
	endfunction

	// Unit sphere at the origin scaled by radius r (integer units).
	task automatic test_sphere(int r);
		logic [31:0] one32, negr2;
		one32 = ONE;
		negr2 = -(r * r) * ONE;
		load_quadric({one32, one32}, {negr2, one32}, '0, '0, '0);
		send_ray(0, 0, -5 * ONE, 0, 0, ONE);          // straight through
		send_ray(0, 0, 0, ONE, 0, 0);                 // from inside
		send_ray(0, 3 * r * ONE, -5 * ONE, 0, 0, ONE);// passes by
		send_ray(ONE, ONE, ONE, 0, 0, 0);             // zero direction
		send_ray(r * ONE, 0, -4 * ONE, 0, 0, ONE);    // grazing
		send_ray(0, 0, 5 * ONE, 0, 0, ONE);           // sphere behind origin
		start <= 1'b0;
	endtask

	task automatic test_extremes();
		logic signed [31:0] mx, mn;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		load_quadric('1, '1, '1, '1, '1);
		send_ray(mx, mx, mx, mx, mx, mx);
		send_ray(mn, mn, mn, mn, mn, mn);
		start <= 1'b0;
		load_quadric({2{mx}}, {2{mx}}, {2{mn}}, {2{mn}}, {2{mx}});
		send_ray(mx, mn, mx, mn, mx, mn);
		send_ray(mn, mx, mn, mx, mn, mx);
		send_ray(0, 0, 0, ONE, ONE, ONE);
		start <= 1'b0;
		load_quadric({mx, mn}, {mn, mx}, {mx, mn}, {mn, mx}, {mx, mn});
		send_ray(mx, mx, mx, -1, -1, -1);
		send_ray(-1, -1, -1, mn, mn, mn);
		send_ray(1, 1, 1, 1, 1, 1);
		start <= 1'b0;
		// indexes past the last register must leave the coefficients alone
		drain_pipeline();
		for (int i = REG_YW_ZW + 1; i < (1 << CFG_IDX_W); i++)
			write_coef(CFG_IDX_W'(i), {$urandom, $urandom});
		send_ray(ONE, 0, 0, 0, ONE, 0);
		start <= 1'b0;
		load_quadric('0, '0, '0, '0, '0);
		send_ray(ONE, ONE, ONE, ONE, ONE, ONE);
		start <= 1'b0;
	endtask

	task automatic test_random(int pct, int n_settings, int per_setting);
		bit wide;
		idle_pct = pct;
		for (int k = 0; k < n_settings; k++) begin
			wide = ($urandom_range(3) == 0);
			load_quadric(rand_coef_pair(wide), rand_coef_pair(wide),
				rand_coef_pair(wide), rand_coef_pair(wide), rand_coef_pair(wide));
			for (int n = 0; n < per_setting; n++) begin
				if ($urandom_range(19) == 0)
					send_ray(rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
				else
					send_ray(rand_coord(), rand_coord(), rand_coord(),
						rand_coord(), rand_coord(), rand_coord());
			end
			start <= 1'b0;
		end
		idle_pct = 0;
	endtask

	initial begin
		for (int i = 0; i < NUM_REGS; i++) coef_regs[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_ray(ONE, ONE, ONE, ONE, 0, 0);   // reset coefficients: degenerate
		start <= 1'b0;
		test_sphere(1);
		test_sphere(3);
		test_extremes();
		test_random(0, 8, 30);
		test_random(65, 8, 30);
		test_random(21, 8, 30);
		drain_pipeline();
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		$display("Sent %0d rays over %0d register writes: %0d hits, %0d misses, %0d degenerate",
			rays_sent, cfg_writes, n_hit, n_miss, n_degen);
		if (errors == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
